FILE: rtl/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; used by mcr_step, mcr_point and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mcr_pkg;

  localparam int COORD_BITS     = 12;
  localparam int RADIUS_BITS    = 11;
  localparam int DEC_BITS       = RADIUS_BITS + 4;
  localparam int OUT_BITS       = COORD_BITS + 2;
  localparam int SUM_BITS       = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam int POINTS_PER_RUN = 8;
  localparam int POINT_IDX_BITS = 3;

  localparam int IN_DATA_BITS  = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

  // Decision update terms
  localparam logic [DEC_BITS-1:0] DEC_INIT     = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DEC_INC_KEEP = DEC_BITS'(6);
  localparam logic [DEC_BITS-1:0] DEC_INC_DIAG = DEC_BITS'(10);

  localparam logic [POINT_IDX_BITS-1:0] LAST_POINT_IDX = POINT_IDX_BITS'(POINTS_PER_RUN - 1);

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  typedef struct packed {
    logic                   active;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] offset_x;
    logic [RADIUS_BITS-1:0] offset_y;
    logic [DEC_BITS-1:0]    decision;
  } circle_state_t;

  // One run of eight symmetric points
  typedef struct packed {
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] offset_x;
    logic [RADIUS_BITS-1:0] offset_y;
    logic                   done;
  } run_t;

endpackage

`default_nettype wire

FILE: rtl/mcr_step.sv
// Next-state logic of the circle walker: start and step update of offsets and decision.
// Depends on mcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcr_step (
  input  var mcr_pkg::circle_state_t      state_i,
  input  var mcr_pkg::kind_e              kind_i,
  input  wire [mcr_pkg::COORD_BITS-1:0]   center_x_i,
  input  wire [mcr_pkg::COORD_BITS-1:0]   center_y_i,
  input  wire [mcr_pkg::RADIUS_BITS-1:0]  radius_i,
  output mcr_pkg::circle_state_t          state_o,
  output logic                            emit_o,
  output mcr_pkg::run_t                   run_o
);

  logic [mcr_pkg::RADIUS_BITS:0]   x_next;
  logic [mcr_pkg::RADIUS_BITS-1:0] y_next;
  logic [mcr_pkg::DEC_BITS-1:0]    x4;
  logic [mcr_pkg::DEC_BITS-1:0]    y4;
  logic                            done;

  assign x4 = mcr_pkg::DEC_BITS'(state_i.offset_x) << 2;
  assign y4 = mcr_pkg::DEC_BITS'(state_i.offset_y) << 2;

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    done    = 1'b0;
    x_next  = {1'b0, state_i.offset_x} + 1'b1;
    y_next  = state_i.offset_y;
    if (kind_i == mcr_pkg::KIND_START) begin
      state_o.center_x = center_x_i;
      state_o.center_y = center_y_i;
      state_o.offset_x = '0;
      state_o.offset_y = radius_i;
      state_o.decision = mcr_pkg::DEC_INIT - (mcr_pkg::DEC_BITS'(radius_i) << 1);
      done             = (radius_i == '0);
      state_o.active   = !done;
      emit_o           = 1'b1;
    end else if (state_i.active) begin
      if (state_i.decision[mcr_pkg::DEC_BITS-1]) begin
        state_o.decision = state_i.decision + x4 + mcr_pkg::DEC_INC_KEEP;
      end else begin
        state_o.decision = state_i.decision + x4 - y4 + mcr_pkg::DEC_INC_DIAG;
        // y never drops below zero
        if (state_i.offset_y != '0) begin
          y_next = state_i.offset_y - 1'b1;
        end
      end
      state_o.offset_x = x_next[mcr_pkg::RADIUS_BITS-1:0];
      state_o.offset_y = y_next;
      done             = (x_next > {1'b0, y_next});
      state_o.active   = !done;
      emit_o           = 1'b1;
    end
  end

  assign run_o.center_x = state_o.center_x;
  assign run_o.center_y = state_o.center_y;
  assign run_o.offset_x = state_o.offset_x;
  assign run_o.offset_y = state_o.offset_y;
  assign run_o.done     = done;

endmodule

`default_nettype wire

FILE: rtl/mcr_point.sv
// Point generator: one of the eight symmetric points of a run, picked by index.
// Depends on mcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcr_point (
  input  var mcr_pkg::run_t                    run_i,
  input  wire [mcr_pkg::POINT_IDX_BITS-1:0]    idx_i,
  output logic [mcr_pkg::OUT_BITS-1:0]         point_x_o,
  output logic [mcr_pkg::OUT_BITS-1:0]         point_y_o
);

  logic [mcr_pkg::SUM_BITS-1:0] cx;
  logic [mcr_pkg::SUM_BITS-1:0] cy;
  logic [mcr_pkg::SUM_BITS-1:0] dx;
  logic [mcr_pkg::SUM_BITS-1:0] dy;
  logic [mcr_pkg::SUM_BITS-1:0] sx;
  logic [mcr_pkg::SUM_BITS-1:0] sy;

  assign cx = mcr_pkg::SUM_BITS'(run_i.center_x);
  assign cy = mcr_pkg::SUM_BITS'(run_i.center_y);

  // Upper index bit swaps the offsets; the two low bits pick the signs.
  assign dx = idx_i[2] ? mcr_pkg::SUM_BITS'(run_i.offset_y) : mcr_pkg::SUM_BITS'(run_i.offset_x);
  assign dy = idx_i[2] ? mcr_pkg::SUM_BITS'(run_i.offset_x) : mcr_pkg::SUM_BITS'(run_i.offset_y);

  assign sx = idx_i[0] ? (cx - dx) : (cx + dx);
  assign sy = idx_i[1] ? (cy - dy) : (cy + dy);

  assign point_x_o = sx[mcr_pkg::OUT_BITS-1:0];
  assign point_y_o = sy[mcr_pkg::OUT_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/midpoint_circle_rasterizer_unit.sv
// Top level of the midpoint circle rasterizer: input handshake, run queue, point output.
// Depends on mcr_pkg, mcr_step and mcr_point.
`timescale 1ns / 1ps
`default_nettype none

// A start word (tuser = 0) loads a center and radius and yields the eight points of the
// circle at x = 0; each step word (tuser = 1) advances the walk by one column and yields
// the next eight points. A step word while no circle is active yields nothing. Every word
// that yields points produces exactly eight output words, the eighth with tlast set, all
// with tuser set when they are the circle's final set. The output port delivers one point
// per cycle while the output is ready; the state update is done in the accept cycle,
// one run waits in a holding register while the previous run drains, so a new word
// can be taken before the previous run has drained, and a run passes through the
// holding, run and output registers. A step word that yields nothing is just absorbed.
module midpoint_circle_rasterizer_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // center_x [11:0], center_y [23:12], radius [34:24], zero fill above
  input  wire [mcr_pkg::IN_DATA_BITS-1:0]     s_axis_tdata_i,
  // kind
  input  wire                                 s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // point_x [13:0], point_y [27:14], zero fill above
  output logic [mcr_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata_o,
  // last_of_step
  output logic                                m_axis_tlast_o,
  // circle_done
  output logic                                m_axis_tuser_o
);

  localparam int CB = mcr_pkg::COORD_BITS;
  localparam int RB = mcr_pkg::RADIUS_BITS;
  localparam int OB = mcr_pkg::OUT_BITS;

  mcr_pkg::circle_state_t state_q;
  mcr_pkg::circle_state_t state_d;
  mcr_pkg::run_t          step_run;
  logic                   step_emit;
  mcr_pkg::kind_e         in_kind;

  logic                   pend_valid_q;
  mcr_pkg::run_t          pend_q;
  logic                   run_valid_q;
  mcr_pkg::run_t          run_q;
  logic [mcr_pkg::POINT_IDX_BITS-1:0] run_idx_q;

  logic                   out_valid_q;
  logic [OB-1:0]          out_x_q;
  logic [OB-1:0]          out_y_q;
  logic                   out_last_q;
  logic                   out_done_q;

  logic [OB-1:0]          pt_x;
  logic [OB-1:0]          pt_y;

  logic                   s_fire;
  logic                   out_load;
  logic                   run_last;
  logic                   run_load;

  assign in_kind = mcr_pkg::kind_e'(s_axis_tuser_i);

  mcr_step u_step (
    .state_i    (state_q),
    .kind_i     (in_kind),
    .center_x_i (s_axis_tdata_i[CB-1:0]),
    .center_y_i (s_axis_tdata_i[2*CB-1:CB]),
    .radius_i   (s_axis_tdata_i[2*CB+RB-1:2*CB]),
    .state_o    (state_d),
    .emit_o     (step_emit),
    .run_o      (step_run)
  );

  mcr_point u_point (
    .run_i     (run_q),
    .idx_i     (run_idx_q),
    .point_x_o (pt_x),
    .point_y_o (pt_y)
  );

  assign out_load = run_valid_q && (!out_valid_q || m_axis_tready_i);
  assign run_last = (run_idx_q == mcr_pkg::LAST_POINT_IDX);
  assign run_load = pend_valid_q && (!run_valid_q || (out_load && run_last));

  assign s_axis_tready_o = !pend_valid_q || run_load;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s_fire) begin
      state_q <= state_d;
    end
  end

  // Hold one finished run while the previous one drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (s_fire && step_emit) begin
      pend_valid_q <= 1'b1;
    end else if (run_load) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && step_emit) begin
      pend_q <= step_run;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_idx_q   <= '0;
    end else if (run_load) begin
      run_valid_q <= 1'b1;
      run_idx_q   <= '0;
    end else if (out_load) begin
      run_idx_q <= run_idx_q + 1'b1;
      if (run_last) begin
        run_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_load) begin
      run_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= pt_x;
      out_y_q    <= pt_y;
      out_last_q <= run_last;
      out_done_q <= run_q.done;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mcr_pkg::OUT_DATA_BITS'({out_y_q, out_x_q});
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_done_q;

`ifndef NO_ASSERTIONS
  // Index only moves while a run is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_idx_q != '0 |-> run_valid_q)
    else $error("point index set without a run");

  // A step while idle must not queue a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_kind == mcr_pkg::KIND_STEP && !state_q.active) |=> !pend_valid_q)
    else $error("idle step queued a run");

  // A start always queues a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_kind == mcr_pkg::KIND_START) |=> pend_valid_q)
    else $error("start did not queue a run");
`endif

endmodule

`default_nettype wire
